/* hw/rtl/ddr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ddr_pkg
// Shared types and constants of the damped difficulty retarget block.
// ----------------------------------------------------------------------------
package ddr_pkg;

	localparam int unsigned CfgIdxW = 3;

	localparam logic [CfgIdxW-1:0] REG_TIMESPAN = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_HOLD     = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_LIMIT0   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_LIMIT1   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_LIMIT2   = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_LIMIT3   = 3'd5;

	localparam logic [31:0] TIMESPAN_RST = 32'd1209600;
	localparam logic [63:0] LIMIT_LO_RST = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] LIMIT_HI_RST = 64'h0000_0000_FFFF_FFFF;

	// one queued word: compact target, clamped timespan, hold flag
	typedef struct packed {
		logic [31:0] bits;
		logic [32:0] damped;
		logic        hold;
	} ddr_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_CAP,
		ST_NORM,
		ST_FIN
	} ddr_state_t;

endpackage
`default_nettype wire

/* hw/rtl/damped_difficulty_retarget.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// damped_difficulty_retarget
// Damped retarget of a compact difficulty target with limit cap.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive last_bits, last_time, first_time and pulse start while busy
//   is low; the word is taken at that edge. Requests may follow back to back
//   until queue and front register hold two words, then busy rises.
//   Result: done is high for exactly one cycle with next_bits; the receiver
//   cannot stall, so results are never held back.
//   Flow: a hold-mode word passes the front register and the queue and is
//   returned as it came. Otherwise front, queue, multiply (one 32x33 limb
//   product per cycle), divide (eight restoring steps per cycle), cap,
//   normalize (one byte per cycle) and encode. The back end takes a new word
//   only when it is through with the last and sets the sustained rate.
//   Config: cfg_valid/cfg_index/cfg_data, always ready; write only while idle.
//   Reset: state, queue and valid flags cleared; config takes reset values.
// ----------------------------------------------------------------------------
module damped_difficulty_retarget #(
	parameter int unsigned TARGET_WIDTH = 256
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output      logic                    busy,
	input  wire logic [31:0]             last_bits,
	input  wire logic [31:0]             last_time,
	input  wire logic [31:0]             first_time,
	output      logic                    done,
	output      logic [31:0]             next_bits,
	input  wire logic                    cfg_valid,
	output      logic                    cfg_ready,
	input  wire logic [ddr_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [63:0]             cfg_data
);
	import ddr_pkg::*;

	logic [31:0]  timespan_q;
	logic         hold_q;
	logic [63:0]  lim_q [4];
	logic [255:0] lim_all;

	logic       take, push, pop, fvld;
	logic [1:0] level;
	ddr_item_t  f_item, q_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timespan_q <= TIMESPAN_RST;
			hold_q     <= 1'b0;
			lim_q[0]   <= LIMIT_LO_RST;
			lim_q[1]   <= LIMIT_LO_RST;
			lim_q[2]   <= LIMIT_LO_RST;
			lim_q[3]   <= LIMIT_HI_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TIMESPAN: timespan_q <= cfg_data[31:0];
				REG_HOLD:     hold_q     <= cfg_data[0];
				REG_LIMIT0:   lim_q[0]   <= cfg_data;
				REG_LIMIT1:   lim_q[1]   <= cfg_data;
				REG_LIMIT2:   lim_q[2]   <= cfg_data;
				REG_LIMIT3:   lim_q[3]   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign lim_all = {lim_q[3], lim_q[2], lim_q[1], lim_q[0]};

	// room check covers the word still in the front register
	assign fvld = push;
	assign busy = ({1'b0, level} + {2'b0, fvld}) >= 3'd2;
	assign take = start && !busy;

	ddr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.last_bits  (last_bits),
		.last_time  (last_time),
		.first_time (first_time),
		.timespan   (timespan_q),
		.hold       (hold_q),
		.push       (push),
		.item       (f_item)
	);

	ddr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (f_item),
		.pop    (pop),
		.rdata  (q_item),
		.level  (level)
	);

	ddr_back #(.W(TARGET_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (level != 2'd0),
		.item      (q_item),
		.pop       (pop),
		.timespan  (timespan_q),
		.limit     (lim_all[TARGET_WIDTH-1:0]),
		.done      (done),
		.next_bits (next_bits)
	);

endmodule
`default_nettype wire

/* hw/rtl/ddr_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ddr_front
// Registers a request and computes the damped, clamped timespan.
// ----------------------------------------------------------------------------
module ddr_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               take,
	input  wire logic [31:0]        last_bits,
	input  wire logic [31:0]        last_time,
	input  wire logic [31:0]        first_time,
	input  wire logic [31:0]        timespan,
	input  wire logic               hold,
	output      logic               push,
	output      ddr_pkg::ddr_item_t item
);
	import ddr_pkg::*;

	logic        vld_s1;
	logic [31:0] bits_s1, lt_s1, ft_s1;
	logic signed [34:0] diff, qt, dmp;
	logic [32:0] lo, hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			bits_s1 <= last_bits;
			lt_s1   <= last_time;
			ft_s1   <= first_time;
		end
	end

	always_comb begin
		diff = $signed({3'b0, lt_s1}) - $signed({3'b0, ft_s1}) - $signed({3'b0, timespan});
		// divide by eight, truncating toward zero
		qt   = (diff + (diff[34] ? 35'sd7 : 35'sd0)) >>> 3;
		dmp  = $signed({3'b0, timespan}) + qt;
		lo   = {1'b0, timespan} - {3'b0, timespan[31:2]};
		hi   = {1'b0, timespan} + {2'b0, timespan[31:1]};
		item.bits = bits_s1;
		item.hold = hold;
		if (dmp < $signed({2'b0, lo})) begin
			item.damped = lo;
		end else if (dmp > $signed({2'b0, hi})) begin
			item.damped = hi;
		end else begin
			item.damped = dmp[32:0];
		end
	end

	assign push = vld_s1;

endmodule
`default_nettype wire

/* hw/rtl/ddr_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ddr_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module ddr_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire ddr_pkg::ddr_item_t wdata,
	input  wire logic               pop,
	output      ddr_pkg::ddr_item_t rdata,
	output      logic [1:0]         level
);
	import ddr_pkg::*;

	ddr_item_t mem_q [2];
	logic      wp_q, rp_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	assign rdata = mem_q[rp_q];
	assign level = cnt_q;

endmodule
`default_nettype wire

/* hw/rtl/ddr_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ddr_back
// Decode, multiply, divide, cap and re-encode one queued word, or pass a hold-mode word through unchanged.
// ----------------------------------------------------------------------------
module ddr_back #(
	parameter int unsigned W = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               avail,
	input  wire ddr_pkg::ddr_item_t item,
	output      logic               pop,
	input  wire logic [31:0]        timespan,
	input  wire logic [W-1:0]       limit,
	output      logic               done,
	output      logic [31:0]        next_bits
);
	import ddr_pkg::*;

	localparam int unsigned WP  = ((W + 31) / 32) * 32;
	localparam int unsigned NL  = WP / 32;
	localparam int unsigned NB  = WP / 8;
	localparam int unsigned CW  = $clog2(NB);
	localparam int unsigned SW  = $clog2(NB + 2);
	localparam logic [WP-1:0] MASK = WP'({W{1'b1}});

	ddr_state_t st_q, st_d;
	logic [WP-1:0] v_q, v_d;
	logic [32:0]   d_q;
	logic [32:0]   cy_q, cy_d;
	logic [31:0]   rem_q, rem_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [SW-1:0] sz_q, sz_d;
	logic          done_q, done_d;
	logic [31:0]   nb_q, nb_d;

	logic [WP-1:0] dec;
	logic [7:0]    esz, sb;
	logic [64:0]   prod;
	logic [32:0]   cur;
	logic [23:0]   mant;

	// compact decode: mantissa placed by exponent, clipped to W
	always_comb begin
		esz = item.bits[31:24];
		sb  = esz - 8'd3;
		if (esz <= 8'd3) begin
			dec = WP'(item.bits[22:0] >> {(2'd3 - esz[1:0]), 3'b000});
		end else if (32'(sb) >= NB) begin
			dec = '0;
		end else begin
			dec = WP'(item.bits[22:0]) << {sb, 3'b000};
		end
		dec = dec & MASK;
	end

	always_comb begin
		st_d   = st_q;
		v_d    = v_q;
		cy_d   = cy_q;
		rem_d  = rem_q;
		cnt_d  = cnt_q;
		sz_d   = sz_q;
		done_d = 1'b0;
		nb_d   = nb_q;
		pop    = 1'b0;
		prod   = (65'(v_q[31:0]) * 65'(d_q)) + 65'(cy_q);
		cur    = '0;
		mant   = v_q[WP-1 -: 24];
		case (st_q)
			ST_IDLE: begin
				if (avail) begin
					pop = 1'b1;
					if (item.hold) begin
						nb_d   = item.bits;
						done_d = 1'b1;
					end else begin
						v_d   = dec;
						cy_d  = '0;
						cnt_d = CW'(NL - 1);
						st_d  = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				// bottom limb first; each product limb rotates in at the top
				v_d   = {prod[31:0], v_q[WP-1:32]};
				cy_d  = prod[64:32];
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					v_d   = {prod[31:0], v_q[WP-1:32]} & MASK;
					rem_d = '0;
					cnt_d = CW'(NB - 1);
					st_d  = (timespan == '0) ? ST_CAP : ST_DIV;
					if (timespan == '0) v_d = '0;
				end
			end
			ST_DIV: begin
				// eight restoring steps per cycle, quotient shifts in at the bottom
				for (int k = 0; k < 8; k++) begin
					cur = {rem_d, v_d[WP-1]};
					v_d = v_d << 1;
					if (cur >= {1'b0, timespan}) begin
						rem_d  = 32'(cur - {1'b0, timespan});
						v_d[0] = 1'b1;
					end else begin
						rem_d = cur[31:0];
					end
				end
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) st_d = ST_CAP;
			end
			ST_CAP: begin
				if ((v_q & MASK) > WP'(limit)) begin
					v_d = WP'(limit);
				end else begin
					v_d = v_q & MASK;
				end
				sz_d = SW'(NB);
				st_d = ST_NORM;
			end
			ST_NORM: begin
				if (sz_q == '0 || v_q[WP-1 -: 8] != 8'd0) begin
					st_d = ST_FIN;
				end else begin
					v_d  = v_q << 8;
					sz_d = sz_q - 1'b1;
				end
			end
			ST_FIN: begin
				if (mant[23]) begin
					nb_d = {8'(sz_q) + 8'd1, 8'd0, mant[23:8]};
				end else begin
					nb_d = {8'(sz_q), mant};
				end
				done_d = 1'b1;
				st_d   = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		v_q   <= v_d;
		cy_q  <= cy_d;
		rem_q <= rem_d;
		cnt_q <= cnt_d;
		sz_q  <= sz_d;
		nb_q  <= nb_d;
		if (st_q == ST_IDLE && avail && !item.hold) d_q <= item.damped;
	end

	assign done      = done_q;
	assign next_bits = nb_q;

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV) |=> (st_q == ST_DIV || st_q == ST_CAP))
		else $error("divide left early");
	a_norm_end: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_NORM && sz_q == '0) |=> (st_q == ST_FIN))
		else $error("normalize ran past zero");
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(st_q == ST_FIN) || $past(pop && item.hold)))
		else $error("result without source");

endmodule
`default_nettype wire
